// ===== src/swt_pkg.sv =====
// Shared types and constants for the sleep/wakeup timer table.
// Used by swt_ctrl, swt_datapath and sleep_wakeup_timer_table_top.
package swt_pkg;

  localparam int FUNC_W = 2;
  localparam int PID_W = 6;
  localparam int DUR_W = 32;
  localparam int TICK_W = 48;
  localparam int SEC_W = 44;
  localparam int MS_W = 54;
  localparam int REM_W = 5;

  localparam int SEC_DIV = 18;
  localparam int MS_PER_TICK = 55;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SLEEP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK_START,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic item_load;
    logic walk_start;
    logic walk_en;
    logic finish_emit;
  } cmd_t;

  typedef struct packed {
    logic walk_needed;
    logic walk_hold;
    logic walk_last;
    logic out_free;
  } status_t;

endpackage

// ===== src/swt_ctrl.sv =====
// Controller state machine for the sleep/wakeup timer table.
// Depends on swt_pkg; drives commands into swt_datapath.
module swt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  swt_pkg::status_t status,
  output swt_pkg::cmd_t    cmd,
  output logic             req_stall
);
  import swt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.item_load = 1'b1;
          state_next = status.walk_needed ? ST_WALK_START : ST_FINISH;
        end
      end
      ST_WALK_START: begin
        cmd.walk_start = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_en = 1'b1;
        if (!status.walk_hold && status.walk_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish_emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/swt_datapath.sv =====
// Datapath of the sleep/wakeup timer table: counters, active bits, deadline
// memory, table walk and result register. Depends on swt_pkg.
module swt_datapath #(
  parameter int NUM_PROCESSES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  swt_pkg::cmd_t               cmd,
  output swt_pkg::status_t            status,
  input  logic [swt_pkg::FUNC_W-1:0]  func,
  input  logic [swt_pkg::PID_W-1:0]   pid,
  input  logic [swt_pkg::DUR_W-1:0]   sleep_dur,
  input  logic                        res_stall,
  output logic                        res_valid,
  output logic                        wake_valid,
  output logic [swt_pkg::PID_W-1:0]   woken_pid,
  output logic                        last,
  output logic [swt_pkg::TICK_W-1:0]  elapsed_ticks,
  output logic [swt_pkg::SEC_W-1:0]   elapsed_seconds,
  output logic [swt_pkg::MS_W-1:0]    elapsed_ms
);
  import swt_pkg::*;

  // Only process numbers that fit the pid field can ever become active.
  localparam int DEPTH = (NUM_PROCESSES < (1 << PID_W)) ? NUM_PROCESSES : (1 << PID_W);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [TICK_W-1:0] tick_count;
  logic [SEC_W-1:0]  sec_count;
  logic [REM_W-1:0]  sec_rem;
  logic [MS_W-1:0]   ms_count;
  logic [TICK_W-1:0] next_check;
  logic [DEPTH-1:0]  active;
  logic [TICK_W-1:0] dl_mem [DEPTH];
  logic [TICK_W-1:0] rd_data;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  pend_idx;
  logic              pend_valid;

  logic [TICK_W-1:0] tick_plus;
  logic [TICK_W-1:0] sleep_dl;
  logic              pid_ok;
  logic [IDX_W-1:0]  pid_idx;
  logic              cur_active;
  logic              expired;
  logic              out_free;
  logic              walk_hold;
  logic              advance;
  logic              emit_wake;
  logic              walk_last;
  logic [IDX_W-1:0]  rd_addr;
  logic              sleep_write;

  assign tick_plus   = tick_count + TICK_W'(1);
  assign sleep_dl    = tick_count + TICK_W'(sleep_dur);
  assign pid_ok      = {1'b0, pid} < (PID_W + 1)'(DEPTH);
  assign pid_idx     = pid[IDX_W-1:0];
  assign sleep_write = cmd.item_load && (func == FUNC_SLEEP) && pid_ok;

  assign cur_active = active[idx];
  assign expired    = cur_active && (rd_data <= tick_count);
  assign out_free   = !res_valid || !res_stall;
  // A second expiry has to push the held wake out before it can be recorded.
  assign walk_hold  = cmd.walk_en && expired && pend_valid && !out_free;
  assign advance    = cmd.walk_en && !walk_hold;
  assign emit_wake  = advance && expired && pend_valid;
  assign walk_last  = (idx == LAST_IDX);

  // Fetch the next entry when the walk moves on, entry 0 on walk start, otherwise hold the read.
  assign rd_addr = (advance && !walk_last) ? idx + IDX_W'(1) :
                   (cmd.walk_start ? '0 : idx);

  assign status.walk_needed = (func == FUNC_TICK) && (tick_plus >= next_check);
  assign status.walk_hold   = walk_hold;
  assign status.walk_last   = walk_last;
  assign status.out_free    = out_free;

  always_ff @(posedge clk) begin
    if (sleep_write) begin
      dl_mem[pid_idx] <= sleep_dl;
    end
    rd_data <= dl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      sec_count <= '0;
      sec_rem <= '0;
      ms_count <= '0;
      next_check <= '1;
      active <= '0;
      idx <= '0;
      pend_idx <= '0;
      pend_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.item_load) begin
        case (func)
          FUNC_TICK: begin
            tick_count <= tick_plus;
            // Seconds and milliseconds follow the counter, including its wrap.
            if (tick_count == '1) begin
              sec_count <= '0;
              sec_rem <= '0;
              ms_count <= '0;
            end else begin
              ms_count <= ms_count + MS_W'(MS_PER_TICK);
              if (sec_rem == REM_W'(SEC_DIV - 1)) begin
                sec_rem <= '0;
                sec_count <= sec_count + SEC_W'(1);
              end else begin
                sec_rem <= sec_rem + REM_W'(1);
              end
            end
            if (status.walk_needed) begin
              next_check <= '1;
            end
          end
          FUNC_SLEEP: begin
            if (pid_ok) begin
              active[pid_idx] <= 1'b1;
              if (sleep_dl < next_check) begin
                next_check <= sleep_dl;
              end
            end
          end
          FUNC_CANCEL: begin
            if (pid_ok) begin
              active[pid_idx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      if (cmd.walk_start) begin
        idx <= '0;
      end

      if (advance) begin
        if (expired) begin
          active[idx] <= 1'b0;
          pend_idx <= idx;
          pend_valid <= 1'b1;
        end else if (cur_active && (rd_data < next_check)) begin
          next_check <= rd_data;
        end
        if (!walk_last) begin
          idx <= idx + IDX_W'(1);
        end
      end

      if (emit_wake || cmd.finish_emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      if (cmd.finish_emit) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_wake || cmd.finish_emit) begin
      elapsed_ticks <= tick_count;
      elapsed_seconds <= sec_count;
      elapsed_ms <= ms_count;
    end
    if (emit_wake) begin
      wake_valid <= 1'b1;
      woken_pid <= PID_W'(pend_idx);
      last <= 1'b0;
    end else if (cmd.finish_emit) begin
      wake_valid <= pend_valid;
      woken_pid <= pend_valid ? PID_W'(pend_idx) : '0;
      last <= 1'b1;
    end
  end

  a_nonfinal_wakes: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> wake_valid)
    else $error("non-final result without a wake");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    sec_rem < REM_W'(SEC_DIV))
    else $error("seconds remainder out of range");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish_emit |=> !pend_valid && res_valid && last)
    else $error("final result not issued or held wake not cleared");

  a_woken_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && expired |=> !active[$past(idx)])
    else $error("woken entry still active");

endmodule

// ===== src/sleep_wakeup_timer_table_top.sv =====
// Sleep/wakeup timer table: keeps one wake deadline per process and a 48-bit
// tick counter. A request with func 0 is a tick, 1 a sleep of sleep_dur
// ticks for process pid, 2 a cancel of that process's sleep. Each request
// gives one or more results; the final one has last set, and a tick that
// wakes processes gives one result per woken process in ascending process
// order. A sleep, a cancel or a tick that does not reach the earliest
// recorded deadline needs no walk. A tick that reaches it walks the
// deadline memory one entry per cycle, read port limited, except while a
// stalled result side holds the walk, and then issues the final result.
// Depends on swt_pkg, swt_ctrl and swt_datapath.
module sleep_wakeup_timer_table_top #(
  parameter int NUM_PROCESSES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [swt_pkg::FUNC_W-1:0]  func,
  input  logic [swt_pkg::PID_W-1:0]   pid,
  input  logic [swt_pkg::DUR_W-1:0]   sleep_dur,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        wake_valid,
  output logic [swt_pkg::PID_W-1:0]   woken_pid,
  output logic                        last,
  output logic [swt_pkg::TICK_W-1:0]  elapsed_ticks,
  output logic [swt_pkg::SEC_W-1:0]   elapsed_seconds,
  output logic [swt_pkg::MS_W-1:0]    elapsed_ms
);
  import swt_pkg::*;

  cmd_t    cmd;
  status_t status;

  swt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .status    (status),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  swt_datapath #(
    .NUM_PROCESSES (NUM_PROCESSES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .func            (func),
    .pid             (pid),
    .sleep_dur       (sleep_dur),
    .res_stall       (res_stall),
    .res_valid       (res_valid),
    .wake_valid      (wake_valid),
    .woken_pid       (woken_pid),
    .last            (last),
    .elapsed_ticks   (elapsed_ticks),
    .elapsed_seconds (elapsed_seconds),
    .elapsed_ms      (elapsed_ms)
  );

endmodule
